FILE: rtl/frrx_pkg.sv
// ----------------------------------------------------------------------------
// frrx_pkg: shared types, constants and functions for the framed ring receiver
// Holds ring/frame store sizes, item structs, protocol bytes, ring address
// arithmetic and the byte-wide CRC-16/MODBUS update.
// ----------------------------------------------------------------------------
package frrx_pkg;

    // Store sizes
    localparam int RING_DEPTH = 1024;
    localparam int FRAME_MAX  = 256;

    // Ring index, ring count and modular-sum widths
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int RING_CW = $clog2(RING_DEPTH + 1);
    localparam int RING_SW = RING_CW + 1;

    // Frame store index and frame length widths
    localparam int FRAME_AW = $clog2(FRAME_MAX);
    localparam int FL_W     = $clog2(FRAME_MAX + 1);

    // Header length field and its compare width
    localparam int LEN_W = 16;
    localparam int CMP_W = LEN_W + 1;

    // Protocol bytes and limits
    localparam logic [7:0]       HEADER_BYTE   = 8'hAA;
    localparam logic [7:0]       END_BYTE      = 8'h0A;
    localparam logic [LEN_W-1:0] MIN_FRAME     = LEN_W'(7);
    localparam logic [LEN_W-1:0] FRAME_MAX_LEN = LEN_W'(FRAME_MAX);
    localparam logic [CMP_W-1:0] RING_MAX_LEN  = CMP_W'(RING_DEPTH);
    localparam logic [RING_CW-1:0] SCAN_HOLD   = RING_CW'(6);

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Item pushed in or reading out
    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef struct packed
    {
        logic       func;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed
    {
        logic       accepted;
        logic       frame_ready;
        logic [8:0] frame_length;
        logic       crc_ok;
        logic       read_valid;
        logic [7:0] data_byte;
        logic       last;
    } out_item_t;

    // Ring position head + off, wrapped; off never exceeds the ring depth
    function automatic logic [RING_AW-1:0] ring_addr(input logic [RING_AW-1:0] head,
                                                     input logic [RING_CW-1:0] off);
        logic [RING_SW-1:0] sum;
        sum = RING_SW'(head) + RING_SW'(off);
        if (sum >= RING_SW'(RING_DEPTH))
        begin
            sum = sum - RING_SW'(RING_DEPTH);
        end
        return sum[RING_AW-1:0];
    endfunction

    // Fold one byte into the CRC, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/frrx_ram.sv
// ----------------------------------------------------------------------------
// frrx_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module frrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/framed_ring_receiver_crc16.sv
// ----------------------------------------------------------------------------
// framed_ring_receiver_crc16: length-prefixed frame receiver with CRC-16/MODBUS
// Buffers received bytes in a ring, extracts 0xAA-headed frames into a frame
// store, checks their CRC and hands frame bytes out on read items.
// ----------------------------------------------------------------------------
// Each item returns exactly one result item. An item is accepted, the ring
// scan is checked and the result is loaded; a read that returns a frame byte
// also waits for the frame store read. The scan drops non-header bytes from
// the ring head and drops the header byte on a bad length or a bad end byte;
// it stops when a header is found but its frame is not complete yet, and it
// copies a complete frame into the frame store.
// The single read port of the ring memory fetches every header, length, end
// and payload byte, one per cycle, with registered read data. The next item
// is taken as soon as the result is loaded into the output register, even
// while it waits there.
// ----------------------------------------------------------------------------
module framed_ring_receiver_crc16 (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  frrx_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output frrx_pkg::out_item_t result
);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SCAN,
        ST_HEAD,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_END,
        ST_COPY,
        ST_FINISH,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [frrx_pkg::RING_AW-1:0] ring_head_reg, ring_head_next;
    logic [frrx_pkg::RING_CW-1:0] ring_count_reg, ring_count_next;
    logic [frrx_pkg::FL_W-1:0]    pending_len_reg, pending_len_next;
    logic [frrx_pkg::FL_W-1:0]    read_pos_reg, read_pos_next;
    logic                         crc_ok_reg, crc_ok_next;
    logic [7:0]                   len_hi_reg, len_hi_next;
    logic [frrx_pkg::FL_W-1:0]    len_reg, len_next;
    logic [frrx_pkg::FL_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                         cp_vld_reg, cp_vld_next;
    logic [frrx_pkg::FL_W-1:0]    cp_idx_reg, cp_idx_next;
    logic [15:0]                  crc_reg, crc_next;
    logic [15:0]                  got_reg, got_next;
    logic                         acc_reg, acc_next;
    logic                         rv_reg, rv_next;
    logic                         last_reg, last_next;
    logic [7:0]                   data_reg, data_next;
    frrx_pkg::out_item_t          result_reg, result_next;
    logic                         result_valid_reg, result_valid_next;

    // Memory ports
    logic                          ring_wr_en;
    logic [frrx_pkg::RING_AW-1:0]  ring_wr_addr;
    logic                          ring_rd_en;
    logic [frrx_pkg::RING_AW-1:0]  ring_rd_addr;
    logic [7:0]                    ring_rdata;
    logic                          frame_wr_en;
    logic                          frame_rd_en;
    logic [frrx_pkg::FRAME_AW-1:0] frame_rd_addr;
    logic [7:0]                    frame_rdata;

    // Header decode from the length bytes
    logic [frrx_pkg::LEN_W-1:0] len16;
    logic                       len_ok;
    logic                       len_fits;
    logic                       item_fire;

    assign item_fire = item_valid && item_ready;
    assign len16     = {len_hi_reg, ring_rdata};
    assign len_ok    = (len16 >= frrx_pkg::MIN_FRAME) && (len16 <= frrx_pkg::FRAME_MAX_LEN)
                       && ({1'b0, len16} <= frrx_pkg::RING_MAX_LEN);
    assign len_fits  = frrx_pkg::CMP_W'(len16) <= frrx_pkg::CMP_W'(ring_count_reg);

    // Ring store: written by pushes, read by the scan
    frrx_ram #(
        .WIDTH (8),
        .DEPTH (frrx_pkg::RING_DEPTH)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (item.byte_value),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rdata)
    );

    // Frame store: written by the copy, read by read items
    frrx_ram #(
        .WIDTH (8),
        .DEPTH (frrx_pkg::FRAME_MAX)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frame_wr_en),
        .wr_addr (cp_idx_reg[frrx_pkg::FRAME_AW-1:0]),
        .wr_data (ring_rdata),
        .rd_en   (frame_rd_en),
        .rd_addr (frame_rd_addr),
        .rd_data (frame_rdata)
    );

    assign ring_wr_addr  = frrx_pkg::ring_addr(ring_head_reg, ring_count_reg);
    assign frame_rd_addr = read_pos_reg[frrx_pkg::FRAME_AW-1:0];
    assign frame_wr_en   = (state_reg == ST_COPY) && cp_vld_reg;

    // Next-state and datapath logic
    always_comb
    begin
        state_next        = state_reg;
        ring_head_next    = ring_head_reg;
        ring_count_next   = ring_count_reg;
        pending_len_next  = pending_len_reg;
        read_pos_next     = read_pos_reg;
        crc_ok_next       = crc_ok_reg;
        len_hi_next       = len_hi_reg;
        len_next          = len_reg;
        issue_idx_next    = issue_idx_reg;
        cp_vld_next       = 1'b0;
        cp_idx_next       = cp_idx_reg;
        crc_next          = crc_reg;
        got_next          = got_reg;
        acc_next          = acc_reg;
        rv_next           = rv_reg;
        last_next         = last_reg;
        data_next         = data_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        ring_wr_en        = 1'b0;
        ring_rd_en        = 1'b0;
        ring_rd_addr      = ring_head_reg;
        frame_rd_en       = 1'b0;

        unique case (state_reg)
            // Take an item: store a pushed byte or fetch the next frame byte
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    acc_next   = 1'b0;
                    rv_next    = 1'b0;
                    last_next  = 1'b0;
                    data_next  = 8'h00;
                    state_next = ST_SCAN;
                    if (item.func == frrx_pkg::FUNC_PUSH)
                    begin
                        if (ring_count_reg < frrx_pkg::RING_CW'(frrx_pkg::RING_DEPTH))
                        begin
                            ring_wr_en      = 1'b1;
                            ring_count_next = ring_count_reg + frrx_pkg::RING_CW'(1);
                            acc_next        = 1'b1;
                        end
                    end
                    else if (pending_len_reg != '0)
                    begin
                        frame_rd_en = 1'b1;
                        rv_next     = 1'b1;
                        state_next  = ST_READ_WAIT;
                        if (read_pos_reg + frrx_pkg::FL_W'(1) >= pending_len_reg)
                        begin
                            last_next        = 1'b1;
                            pending_len_next = '0;
                            read_pos_next    = '0;
                            crc_ok_next      = 1'b0;
                        end
                        else
                        begin
                            read_pos_next = read_pos_reg + frrx_pkg::FL_W'(1);
                        end
                    end
                end
            end

            // Capture the frame byte
            ST_READ_WAIT:
            begin
                data_next  = frame_rdata;
                state_next = ST_SCAN;
            end

            // Stop when a frame is pending or too few bytes; else fetch head
            ST_SCAN:
            begin
                if ((pending_len_reg != '0) || (ring_count_reg <= frrx_pkg::SCAN_HOLD))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = ring_head_reg;
                    state_next   = ST_HEAD;
                end
            end

            // Drop a non-header byte; else fetch the length high byte
            ST_HEAD:
            begin
                if (ring_rdata != frrx_pkg::HEADER_BYTE)
                begin
                    ring_head_next  = frrx_pkg::ring_addr(ring_head_reg, frrx_pkg::RING_CW'(1));
                    ring_count_next = ring_count_reg - frrx_pkg::RING_CW'(1);
                    state_next      = ST_SCAN;
                end
                else
                begin
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = frrx_pkg::ring_addr(ring_head_reg, frrx_pkg::RING_CW'(2));
                    state_next   = ST_LEN_HI;
                end
            end

            // Hold the high length byte, fetch the low one
            ST_LEN_HI:
            begin
                len_hi_next  = ring_rdata;
                ring_rd_en   = 1'b1;
                ring_rd_addr = frrx_pkg::ring_addr(ring_head_reg, frrx_pkg::RING_CW'(3));
                state_next   = ST_LEN_LO;
            end

            // Check the length; wait for an incomplete frame; fetch the end byte
            ST_LEN_LO:
            begin
                if (!len_ok)
                begin
                    ring_head_next  = frrx_pkg::ring_addr(ring_head_reg, frrx_pkg::RING_CW'(1));
                    ring_count_next = ring_count_reg - frrx_pkg::RING_CW'(1);
                    state_next      = ST_SCAN;
                end
                else if (!len_fits)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    len_next     = frrx_pkg::FL_W'(len16);
                    ring_rd_en   = 1'b1;
                    ring_rd_addr = frrx_pkg::ring_addr(ring_head_reg,
                                       frrx_pkg::RING_CW'(len16 - frrx_pkg::LEN_W'(1)));
                    state_next   = ST_END;
                end
            end

            // Drop on a bad end byte; else start the copy
            ST_END:
            begin
                if (ring_rdata != frrx_pkg::END_BYTE)
                begin
                    ring_head_next  = frrx_pkg::ring_addr(ring_head_reg, frrx_pkg::RING_CW'(1));
                    ring_count_next = ring_count_reg - frrx_pkg::RING_CW'(1);
                    state_next      = ST_SCAN;
                end
                else
                begin
                    issue_idx_next = '0;
                    crc_next       = frrx_pkg::CRC_INIT;
                    state_next     = ST_COPY;
                end
            end

            // Stream ring bytes into the frame store, folding in the CRC
            ST_COPY:
            begin
                if (issue_idx_reg < len_reg)
                begin
                    ring_rd_en     = 1'b1;
                    ring_rd_addr   = frrx_pkg::ring_addr(ring_head_reg,
                                                         frrx_pkg::RING_CW'(issue_idx_reg));
                    issue_idx_next = issue_idx_reg + frrx_pkg::FL_W'(1);
                    cp_vld_next    = 1'b1;
                    cp_idx_next    = issue_idx_reg;
                end
                if (cp_vld_reg)
                begin
                    if (cp_idx_reg < len_reg - frrx_pkg::FL_W'(3))
                    begin
                        crc_next = frrx_pkg::crc16_byte(crc_reg, ring_rdata);
                    end
                    if (cp_idx_reg == len_reg - frrx_pkg::FL_W'(3))
                    begin
                        got_next[15:8] = ring_rdata;
                    end
                    if (cp_idx_reg == len_reg - frrx_pkg::FL_W'(2))
                    begin
                        got_next[7:0] = ring_rdata;
                    end
                    if (cp_idx_reg == len_reg - frrx_pkg::FL_W'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // Release the frame's ring bytes and make the frame pending
            ST_FINISH:
            begin
                ring_head_next   = frrx_pkg::ring_addr(ring_head_reg,
                                                       frrx_pkg::RING_CW'(len_reg));
                ring_count_next  = ring_count_reg - frrx_pkg::RING_CW'(len_reg);
                pending_len_next = len_reg;
                read_pos_next    = '0;
                crc_ok_next      = (crc_reg == got_reg);
                state_next       = ST_DONE;
            end

            // Load the result once the output register is free
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.accepted     = acc_reg;
                    result_next.frame_ready  = (pending_len_reg != '0);
                    result_next.frame_length = 9'(pending_len_reg);
                    result_next.crc_ok       = crc_ok_reg && (pending_len_reg != '0);
                    result_next.read_valid   = rv_reg;
                    result_next.data_byte    = data_reg;
                    result_next.last         = last_reg;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ring_head_reg    <= '0;
            ring_count_reg   <= '0;
            pending_len_reg  <= '0;
            read_pos_reg     <= '0;
            crc_ok_reg       <= 1'b0;
            cp_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ring_head_reg    <= ring_head_next;
            ring_count_reg   <= ring_count_next;
            pending_len_reg  <= pending_len_next;
            read_pos_reg     <= read_pos_next;
            crc_ok_reg       <= crc_ok_next;
            cp_vld_reg       <= cp_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_hi_reg    <= len_hi_next;
        len_reg       <= len_next;
        issue_idx_reg <= issue_idx_next;
        cp_idx_reg    <= cp_idx_next;
        crc_reg       <= crc_next;
        got_reg       <= got_next;
        acc_reg       <= acc_next;
        rv_reg        <= rv_next;
        last_reg      <= last_next;
        data_reg      <= data_next;
        result_reg    <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Ring occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= frrx_pkg::RING_CW'(frrx_pkg::RING_DEPTH))
        else $error("ring count exceeds depth");

    // A pending frame always has a legal length
    a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_len_reg != '0) |->
        (pending_len_reg >= frrx_pkg::FL_W'(7)
         && pending_len_reg <= frrx_pkg::FL_W'(frrx_pkg::FRAME_MAX)))
        else $error("pending frame length out of range");

    // The read pointer stays inside the pending frame
    a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_len_reg != '0) |-> (read_pos_reg < pending_len_reg))
        else $error("read position past frame end");

    // Copy writes stay inside the frame being extracted
    a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_wr_en |-> (cp_idx_reg < len_reg))
        else $error("frame store write beyond frame length");

    // A ring write only happens on an accepted push into a non-full ring
    a_ring_write: assert property (@(posedge clk) disable iff (!rst_n)
        ring_wr_en |-> (item_fire && ring_count_reg != frrx_pkg::RING_CW'(frrx_pkg::RING_DEPTH)))
        else $error("ring write without room");

    // A new result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> (result_valid_reg && $stable(result_reg)))
        else $error("waiting result overwritten");

endmodule
